// File: sv/status_led_pattern_renderer_core_defines.svh
// assertion macros shared by the status led renderer checker
`ifndef STATUS_LED_PATTERN_RENDERER_CORE_DEFINES_SVH
`define STATUS_LED_PATTERN_RENDERER_CORE_DEFINES_SVH

// next-cycle implication, masked while reset is low
`define SLPR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slpr check failed");

// next-cycle implication, also checked across reset
`define SLPR_ASSERT_NXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("slpr reset check failed");

`endif

// File: sv/slpr_pkg.sv
// types and constants of the status led pattern renderer
`default_nettype none
package slpr_pkg;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  new_state;
    logic [31:0] now_ms;
  } slpr_in_t;

  typedef struct packed {
    logic [7:0] green_duty;
    logic [7:0] yellow_duty;
    logic [7:0] red_duty;
  } slpr_out_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic load_out;
  } slpr_cmd_t;

  typedef struct packed {
    logic is_render;
    logic need_div;
    logic div_done;
    logic out_free;
  } slpr_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_OUT
  } slpr_state_t;

  typedef enum logic [1:0] {
    CH_GREEN,
    CH_YELLOW,
    CH_RED
  } slpr_ch_t;

  // request opcodes
  localparam logic [2:0] OP_RENDER    = 3'd0;
  localparam logic [2:0] OP_SET_STATE = 3'd1;
  localparam logic [2:0] OP_BUTTON    = 3'd2;
  localparam logic [2:0] OP_BOOT_ANIM = 3'd3;
  localparam logic [2:0] OP_OTA       = 3'd4;

  // led modes
  localparam logic [2:0] MODE_BOOT_OK    = 3'd0;
  localparam logic [2:0] MODE_JOINING    = 3'd1;
  localparam logic [2:0] MODE_JOINED     = 3'd2;
  localparam logic [2:0] MODE_NORMAL     = 3'd3;
  localparam logic [2:0] MODE_SENSOR_ERR = 3'd5;
  localparam logic [2:0] MODE_LINK_LOST  = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_ACTIVE_LOW  = 2'd0;
  localparam logic [1:0] CFG_JOIN_PERIOD = 2'd1;
  localparam logic [1:0] CFG_NORM_PERIOD = 2'd2;
  localparam logic [1:0] CFG_BUTTON_LEN  = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  FULL_DUTY     = 8'hFF;
  localparam logic [31:0] BLINK_MS      = 32'd150;
  localparam logic [31:0] FLASH_MS      = 32'd120;
  localparam int          RAMP_TOTAL_MS = 3000;
  localparam int          JOIN_FLASHES  = 3;
  localparam int          OTA_FLASHES   = 6;

  // breathe divider sizes: 16 bit distance times 255 over a 15 bit half period
  localparam int NUM_W = 24;
  localparam int DEN_W = 15;
  localparam int CNT_W = 5;

endpackage
`default_nettype wire

// File: sv/slpr_div.sv
// restoring divider, one quotient bit per cycle, for the breathe ramp
`default_nettype none
module slpr_div
  import slpr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quot_r, quot_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    den_nxt  = den_r;
    rem_sh   = {rem_r, quot_r[NUM_W-1]};
    diff     = rem_sh - {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      quot_nxt = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt  = diff[DEN_W-1:0];
        quot_nxt = {quot_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[DEN_W-1:0];
        quot_nxt = {quot_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

// File: sv/slpr_dp.sv
// datapath: config registers, pattern state, render evaluation and output register
`default_nettype none
module slpr_dp
  import slpr_pkg::*;
#(
  parameter int RAMP_STEPS   = 40,
  parameter int TICK_STEP_MS = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire slpr_in_t              in_data,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output slpr_out_t                  out_data,
  input  wire slpr_cmd_t             cmd,
  output slpr_sts_t                  sts
);

  localparam int RAMP_MS  = RAMP_TOTAL_MS / RAMP_STEPS;
  // ramp brightness as a multiply by the rounded-up reciprocal of the step count
  localparam int RAMP_X_W = 14;
  localparam int RAMP_SH  = RAMP_X_W + $clog2(RAMP_STEPS);
  localparam int RAMP_REC = ((1 << RAMP_SH) + RAMP_STEPS - 1) / RAMP_STEPS;

  slpr_in_t item_r;

  logic        cfg_al_r;
  logic [15:0] cfg_join_r;
  logic [15:0] cfg_norm_r;
  logic [15:0] cfg_btn_r;

  logic [2:0]  led_mode_r, led_mode_nxt;
  logic        seq_run_r, seq_run_nxt;
  logic [2:0]  seq_idx_r, seq_idx_nxt;
  logic [31:0] seq_dl_r, seq_dl_nxt;
  logic [15:0] phase_r, phase_nxt;
  logic        ramp_run_r, ramp_run_nxt;
  logic [5:0]  ramp_idx_r, ramp_idx_nxt;
  logic [31:0] ramp_dl_r, ramp_dl_nxt;
  logic        flash_run_r, flash_run_nxt;
  logic [3:0]  flash_idx_r, flash_idx_nxt;
  logic [31:0] flash_dl_r, flash_dl_nxt;
  logic [31:0] ovl_until_r, ovl_until_nxt;

  logic [7:0]  base_g_r, base_g_nxt;
  logic [7:0]  base_y_r, base_y_nxt;
  logic [7:0]  base_r_r, base_r_nxt;
  logic        brth_use_r;
  slpr_ch_t    brth_ch_r, brth_ch_nxt;
  logic        ovl_r, ovl_nxt;
  logic        out_valid_r;
  slpr_out_t   out_data_r;

  logic [31:0]         now;
  logic [15:0]         brth_period;
  logic [16:0]         phase_sum;
  logic [15:0]         phase_new;
  logic [DEN_W-1:0]    half;
  logic [15:0]         brth_dist;
  logic [NUM_W-1:0]    num;
  logic [RAMP_X_W-1:0] ramp_x;
  logic [RAMP_X_W+14:0] ramp_prod;
  logic [7:0]          bright;
  logic                brth_act;
  logic                need_div;
  logic                div_done;
  logic [NUM_W-1:0]    div_q;
  logic [7:0]          brth_duty;
  logic [7:0]          g_fin, y_fin, r_fin;

  always_comb begin
    now          = item_r.now_ms;
    brth_period  = (led_mode_r == MODE_JOINING) ? cfg_join_r : cfg_norm_r;
    phase_sum    = {1'b0, phase_r} + 17'(TICK_STEP_MS);
    phase_new    = (phase_sum >= {1'b0, brth_period}) ? 16'd0 : phase_sum[15:0];
    half         = brth_period[15:1];
    brth_dist    = (phase_new < {1'b0, half}) ? phase_new : (brth_period - phase_new);
    // times 255 as shift and subtract
    num          = {brth_dist, 8'h00} - {8'h00, brth_dist};
    ramp_x       = '0;
    ramp_prod    = '0;
    bright       = 8'd0;

    led_mode_nxt  = led_mode_r;
    seq_run_nxt   = seq_run_r;
    seq_idx_nxt   = seq_idx_r;
    seq_dl_nxt    = seq_dl_r;
    phase_nxt     = phase_r;
    ramp_run_nxt  = ramp_run_r;
    ramp_idx_nxt  = ramp_idx_r;
    ramp_dl_nxt   = ramp_dl_r;
    flash_run_nxt = flash_run_r;
    flash_idx_nxt = flash_idx_r;
    flash_dl_nxt  = flash_dl_r;
    ovl_until_nxt = ovl_until_r;
    base_g_nxt    = 8'd0;
    base_y_nxt    = 8'd0;
    base_r_nxt    = 8'd0;
    brth_ch_nxt   = CH_GREEN;
    brth_act      = 1'b0;
    ovl_nxt       = 1'b0;
    need_div      = 1'b0;

    unique case (item_r.op)
      OP_RENDER: begin
        if (flash_run_r) begin
          if (now >= flash_dl_r) begin
            flash_dl_nxt  = now + FLASH_MS;
            flash_idx_nxt = flash_idx_r + 4'd1;
            if (flash_idx_nxt > 4'(OTA_FLASHES * 2)) begin
              flash_run_nxt = 1'b0;
            end
          end
          if (flash_run_nxt && flash_idx_nxt[0]) begin
            base_g_nxt = FULL_DUTY;
            base_y_nxt = FULL_DUTY;
          end
        end else if (ramp_run_r) begin
          if (now >= ramp_dl_r) begin
            ramp_idx_nxt = ramp_idx_r + 6'd1;
            ramp_dl_nxt  = now + 32'(RAMP_MS);
            if (ramp_idx_nxt >= 6'(RAMP_STEPS)) begin
              ramp_run_nxt = 1'b0;
            end
          end
          if (ramp_run_nxt) begin
            // index below the step count keeps the brightness under full duty
            ramp_x    = {ramp_idx_nxt, 8'h00} - {8'h00, ramp_idx_nxt};
            ramp_prod = (RAMP_X_W+15)'(ramp_x) * (RAMP_X_W+15)'(RAMP_REC);
            bright    = ramp_prod[RAMP_SH +: 8];
            case (ramp_idx_nxt[1:0])
              2'd0:    base_r_nxt = bright;
              2'd2:    base_g_nxt = bright;
              default: base_y_nxt = bright;
            endcase
          end
        end else if (seq_run_r && led_mode_r == MODE_BOOT_OK) begin
          if (now >= seq_dl_r) begin
            if (seq_idx_r == 3'd0) begin
              seq_idx_nxt = 3'd1;
              seq_dl_nxt  = now + BLINK_MS;
            end else if (seq_idx_r == 3'd1) begin
              seq_idx_nxt = 3'd2;
              seq_dl_nxt  = now + BLINK_MS;
            end else begin
              seq_run_nxt = 1'b0;
              seq_idx_nxt = 3'd0;
              seq_dl_nxt  = 32'd0;
            end
          end
          if (seq_idx_nxt == 3'd1) base_g_nxt = FULL_DUTY;
        end else if (seq_run_r && led_mode_r == MODE_JOINED) begin
          if (now >= seq_dl_r) begin
            if (seq_idx_r < 3'(JOIN_FLASHES * 2)) begin
              seq_dl_nxt  = now + BLINK_MS;
              seq_idx_nxt = seq_idx_r + 3'd1;
            end else begin
              seq_run_nxt = 1'b0;
              seq_idx_nxt = 3'd0;
              seq_dl_nxt  = 32'd0;
            end
          end
          if (seq_idx_nxt[0]) base_y_nxt = FULL_DUTY;
        end else begin
          case (led_mode_r)
            MODE_JOINING: begin
              brth_act    = 1'b1;
              brth_ch_nxt = CH_YELLOW;
            end
            MODE_NORMAL: begin
              brth_act    = 1'b1;
              brth_ch_nxt = CH_GREEN;
            end
            MODE_SENSOR_ERR: base_r_nxt = FULL_DUTY;
            MODE_LINK_LOST: begin
              brth_act    = 1'b1;
              brth_ch_nxt = CH_RED;
            end
            default: ;
          endcase
          if (brth_act) begin
            phase_nxt = phase_new;
            need_div  = (half != '0);
          end
          ovl_nxt = (ovl_until_r != 32'd0) && (now < ovl_until_r);
        end
      end
      OP_SET_STATE: begin
        if (led_mode_r != item_r.new_state) begin
          led_mode_nxt = item_r.new_state;
          seq_idx_nxt  = 3'd0;
          if (item_r.new_state == MODE_BOOT_OK || item_r.new_state == MODE_JOINED) begin
            seq_run_nxt = 1'b1;
            seq_dl_nxt  = now;
            if (item_r.new_state == MODE_BOOT_OK) phase_nxt = 16'd0;
          end else begin
            seq_run_nxt = 1'b0;
            seq_dl_nxt  = 32'd0;
          end
        end
      end
      OP_BUTTON: ovl_until_nxt = now + {16'd0, cfg_btn_r};
      OP_BOOT_ANIM: begin
        ramp_run_nxt = 1'b1;
        ramp_idx_nxt = 6'd0;
        ramp_dl_nxt  = now;
      end
      OP_OTA: begin
        flash_run_nxt = 1'b1;
        flash_idx_nxt = 4'd0;
        flash_dl_nxt  = now;
      end
      default: ;
    endcase
  end

  slpr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.eval && need_div),
    .dividend (num),
    .divisor  (half),
    .done     (div_done),
    .quot     (div_q)
  );

  // breathe value saturates at full duty
  assign brth_duty = (div_q[NUM_W-1:8] != '0) ? FULL_DUTY : div_q[7:0];

  always_comb begin
    g_fin = (brth_use_r && brth_ch_r == CH_GREEN) ? brth_duty : base_g_r;
    y_fin = (brth_use_r && brth_ch_r == CH_YELLOW) ? brth_duty : base_y_r;
    r_fin = (brth_use_r && brth_ch_r == CH_RED) ? brth_duty : base_r_r;
    if (ovl_r) y_fin = FULL_DUTY;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_al_r    <= 1'b0;
      cfg_join_r  <= 16'd2000;
      cfg_norm_r  <= 16'd5000;
      cfg_btn_r   <= 16'd120;
      led_mode_r  <= MODE_BOOT_OK;
      seq_run_r   <= 1'b0;
      seq_idx_r   <= 3'd0;
      seq_dl_r    <= 32'd0;
      phase_r     <= 16'd0;
      ramp_run_r  <= 1'b0;
      ramp_idx_r  <= 6'd0;
      ramp_dl_r   <= 32'd0;
      flash_run_r <= 1'b0;
      flash_idx_r <= 4'd0;
      flash_dl_r  <= 32'd0;
      ovl_until_r <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ACTIVE_LOW:  cfg_al_r   <= cfg_wdata[0];
          CFG_JOIN_PERIOD: cfg_join_r <= cfg_wdata;
          CFG_NORM_PERIOD: cfg_norm_r <= cfg_wdata;
          CFG_BUTTON_LEN:  cfg_btn_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.eval) begin
        led_mode_r  <= led_mode_nxt;
        seq_run_r   <= seq_run_nxt;
        seq_idx_r   <= seq_idx_nxt;
        seq_dl_r    <= seq_dl_nxt;
        phase_r     <= phase_nxt;
        ramp_run_r  <= ramp_run_nxt;
        ramp_idx_r  <= ramp_idx_nxt;
        ramp_dl_r   <= ramp_dl_nxt;
        flash_run_r <= flash_run_nxt;
        flash_idx_r <= flash_idx_nxt;
        flash_dl_r  <= flash_dl_nxt;
        ovl_until_r <= ovl_until_nxt;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.capture) item_r <= in_data;
    if (cmd.eval) begin
      base_g_r   <= base_g_nxt;
      base_y_r   <= base_y_nxt;
      base_r_r   <= base_r_nxt;
      brth_use_r <= need_div;
      brth_ch_r  <= brth_ch_nxt;
      ovl_r      <= ovl_nxt;
    end
    if (cmd.load_out) begin
      // active low output is the one's complement of the duty
      out_data_r.green_duty  <= g_fin ^ {8{cfg_al_r}};
      out_data_r.yellow_duty <= y_fin ^ {8{cfg_al_r}};
      out_data_r.red_duty    <= r_fin ^ {8{cfg_al_r}};
    end
  end

  assign sts.is_render = (item_r.op == OP_RENDER);
  assign sts.need_div  = need_div;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: sv/slpr_ctrl.sv
// controller state machine sequencing capture, evaluation, divide and output
`default_nettype none
module slpr_ctrl
  import slpr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire slpr_sts_t sts,
  output slpr_cmd_t      cmd
);

  slpr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.eval     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (!sts.is_render) begin
          state_nxt = ST_IDLE;
        end else if (sts.need_div) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // wait here while the previous result is still held
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/status_led_pattern_renderer_core.sv
// Status LED pattern renderer, top level.
// Requests come in on in_valid/in_ready with in_data (op, new_state, now_ms).
// Only a render request produces a result, on out_valid/out_ready with out_data
// holding the green, yellow and red duties. Other requests just update state.
// Configuration is written through cfg_we/cfg_index/cfg_wdata, one register per
// cycle, with no read-back. The user must write it only while no request is
// in flight; the block itself does not enforce this. A non-render request is
// captured and evaluated only; a render request is also loaded into the output
// register, after the 24-step restoring divider when a breathe pattern is shown.
// One request is worked on at a time; the next is taken as soon as the
// current one is done, even while its result still sits in the output register.
// If the receiver stalls, the result is held in the output register, and a
// following render waits for that register to free up before loading.
// Reset (rst_n low, synchronous) clears all pattern state, restores the register
// defaults and empties the output register.
`default_nettype none
module status_led_pattern_renderer_core
  import slpr_pkg::*;
#(
  parameter int RAMP_STEPS   = 40,
  parameter int TICK_STEP_MS = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire slpr_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output slpr_out_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  slpr_cmd_t cmd;
  slpr_sts_t sts;

  slpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  slpr_dp #(
    .RAMP_STEPS   (RAMP_STEPS),
    .TICK_STEP_MS (TICK_STEP_MS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

// File: sv/slpr_chk.sv
// port-level checker for the status led renderer, bound to the top level
`default_nettype none
`include "status_led_pattern_renderer_core_defines.svh"
module slpr_chk
  import slpr_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire slpr_out_t out_data
);

  // output register comes out of reset empty
  `SLPR_ASSERT_NXT_ALWAYS(a_rst_empty, !rst_n, !out_valid)

  // one request at a time: busy right after an acceptance
  `SLPR_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // a fresh result never appears the cycle after acceptance
  `SLPR_ASSERT_NXT(a_no_early_result, in_valid && in_ready, !$rose(out_valid))

  // stalled result holds
  `SLPR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind status_led_pattern_renderer_core slpr_chk u_slpr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
